>>> hw/rtl/sorted_list_engine_core_assert.svh
// Assertion macros shared by the sorted list engine RTL.
`ifndef SORTED_LIST_ENGINE_CORE_ASSERT_SVH
`define SORTED_LIST_ENGINE_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SLIST_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slist: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SLIST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slist: next-cycle check failed");

`endif

>>> hw/rtl/slist_pkg.sv
// Package: sizes, operation codes and memory request type of the sorted list engine.
package slist_pkg;

   localparam int CAPACITY = 32;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int FUNC_W   = 2;
   localparam int COUNT_FIELD_W = 6;

   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_ODDS   = 2'd2;

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [DATA_W-1:0] wr_data;
   } mem_req_type;

endpackage

>>> hw/rtl/slist_if.sv
// Valid/ready channel interfaces for the request and response streams.
interface slist_req_if;
   import slist_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [FUNC_W-1:0]        func;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output func, output value, input ready);
   modport sink   (input valid, input func, input value, output ready);
endinterface

interface slist_rsp_if;
   import slist_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     ok;
   logic [COUNT_FIELD_W-1:0] count;
   logic signed [DATA_W-1:0] smallest;
   logic                     is_empty;
   logic                     is_full;

   modport source (output valid, output ok, output count, output smallest,
                   output is_empty, output is_full, input ready);
   modport sink   (input valid, input ok, input count, input smallest,
                   input is_empty, input is_full, output ready);
endinterface

>>> hw/rtl/slist_ram.sv
// Generic single-clock RAM: one write port, one registered read port.
module slist_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/slist_ctrl.sv
// Sequencer: streams list entries through the RAM for insert, remove and remove-odds.
`include "sorted_list_engine_core_assert.svh"

module slist_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   slist_req_if.sink                 req_ch,
   slist_rsp_if.source               rsp_ch,
   output slist_pkg::mem_req_type    mem_req,
   input  logic [slist_pkg::DATA_W-1:0] mem_rd_data
);
   import slist_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_WR0  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]               state_ff, state_in;
   logic [FUNC_W-1:0]        func_ff, func_in;
   logic signed [DATA_W-1:0] value_ff, value_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [DATA_W-1:0]        small_ff, small_in;
   logic [ADDR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic                     more_ff, more_in;
   logic                     pend_ff, pend_in;
   logic [ADDR_W-1:0]        pend_addr_ff, pend_addr_in;
   logic [CNT_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic                     found_ff, found_in;
   logic                     ok_ff, ok_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_ok_ff, rsp_ok_in;
   logic [COUNT_FIELD_W-1:0] rsp_count_ff, rsp_count_in;
   logic [DATA_W-1:0]        rsp_small_ff, rsp_small_in;
   logic                     rsp_empty_ff, rsp_empty_in;
   logic                     rsp_full_ff, rsp_full_in;

   logic [ADDR_W-1:0]        count_m1;
   logic                     last_pend;
   logic                     found_now;
   logic [CNT_W-1:0]         odds_cnt;
   logic                     list_empty;
   logic                     list_full;
   logic                     rsp_free;

   assign count_m1   = ADDR_W'(count_ff - 1'b1);
   assign last_pend  = pend_ff && (pend_addr_ff == count_m1);
   assign found_now  = found_ff || (mem_rd_data == value_ff);
   assign odds_cnt   = mem_rd_data[0] ? wr_ptr_ff : CNT_W'(wr_ptr_ff + 1'b1);
   assign list_empty = (count_ff == '0);
   assign list_full  = (count_ff == CNT_W'(CAPACITY));
   assign rsp_free   = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      value_in     = value_ff;
      count_in     = count_ff;
      rd_ptr_in    = rd_ptr_ff;
      more_in      = more_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      wr_ptr_in    = wr_ptr_ff;
      found_in     = found_ff;
      ok_in        = ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_count_in = rsp_count_ff;
      rsp_small_in = rsp_small_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_full_in  = rsp_full_ff;
      mem_req      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               func_in   = req_ch.func;
               value_in  = req_ch.value;
               found_in  = 1'b0;
               wr_ptr_in = '0;
               more_in   = 1'b1;
               ok_in     = 1'b0;
               unique case (req_ch.func)
                  FUNC_INSERT: begin
                     if (list_full) begin
                        state_in = ST_DONE;
                     end else if (list_empty) begin
                        state_in = ST_WR0;
                     end else begin
                        rd_ptr_in = count_m1;
                        state_in  = ST_SCAN;
                     end
                  end
                  FUNC_REMOVE, FUNC_ODDS: begin
                     if (list_empty) begin
                        state_in = ST_DONE;
                     end else begin
                        rd_ptr_in = '0;
                        state_in  = ST_SCAN;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // read one entry ahead; data for pend_addr_ff arrives this cycle
            if (more_ff) begin
               mem_req.rd_en = 1'b1;
               mem_req.rd_addr = rd_ptr_ff;
               pend_in       = 1'b1;
               pend_addr_in  = rd_ptr_ff;
               if (func_ff == FUNC_INSERT) begin
                  rd_ptr_in = ADDR_W'(rd_ptr_ff - 1'b1);
                  more_in   = (rd_ptr_ff != '0);
               end else begin
                  rd_ptr_in = ADDR_W'(rd_ptr_ff + 1'b1);
                  more_in   = (rd_ptr_ff != count_m1);
               end
            end

            if (pend_ff) begin
               unique case (func_ff)
                  FUNC_INSERT: begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = ADDR_W'(pend_addr_ff + 1'b1);
                     if ($signed(mem_rd_data) > value_ff) begin
                        mem_req.wr_data = mem_rd_data;
                        if (pend_addr_ff == '0) begin
                           state_in = ST_WR0;
                        end
                     end else begin
                        // insertion point found: drop the read issued this cycle
                        mem_req.wr_data = value_ff;
                        count_in = CNT_W'(count_ff + 1'b1);
                        ok_in    = 1'b1;
                        pend_in  = 1'b0;
                        more_in  = 1'b0;
                        state_in = ST_DONE;
                     end
                  end
                  FUNC_REMOVE: begin
                     if (found_ff) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = ADDR_W'(pend_addr_ff - 1'b1);
                        mem_req.wr_data = mem_rd_data;
                     end
                     found_in = found_now;
                     if (last_pend) begin
                        ok_in = found_now;
                        if (found_now) begin
                           count_in = CNT_W'(count_ff - 1'b1);
                        end
                        state_in = ST_DONE;
                     end
                  end
                  default: begin
                     // remove-odds: compact even entries toward the bottom
                     if (!mem_rd_data[0]) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = wr_ptr_ff[ADDR_W-1:0];
                        mem_req.wr_data = mem_rd_data;
                     end
                     wr_ptr_in = odds_cnt;
                     if (last_pend) begin
                        ok_in = (odds_cnt != count_ff);
                        if (odds_cnt != count_ff) begin
                           count_in = odds_cnt;
                        end
                        state_in = ST_DONE;
                     end
                  end
               endcase
            end
         end

         ST_WR0: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = '0;
            mem_req.wr_data = value_ff;
            count_in = CNT_W'(count_ff + 1'b1);
            ok_in    = 1'b1;
            state_in = ST_DONE;
         end

         default: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_count_in = COUNT_FIELD_W'(count_ff);
               rsp_small_in = list_empty ? '0 : small_ff;
               rsp_empty_in = list_empty;
               rsp_full_in  = list_full;
               state_in     = ST_IDLE;
            end
         end
      endcase

      // entry 0 is shadowed so the smallest value needs no extra read
      small_in = small_ff;
      if (mem_req.wr_en && (mem_req.wr_addr == '0)) begin
         small_in = mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         more_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         more_ff      <= more_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      value_ff     <= value_in;
      small_ff     <= small_in;
      rd_ptr_ff    <= rd_ptr_in;
      pend_addr_ff <= pend_addr_in;
      wr_ptr_ff    <= wr_ptr_in;
      found_ff     <= found_in;
      ok_ff        <= ok_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_count_ff <= rsp_count_in;
      rsp_small_ff <= rsp_small_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign req_ch.ready    = (state_ff == ST_IDLE);
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.ok       = rsp_ok_ff;
   assign rsp_ch.count    = rsp_count_ff;
   assign rsp_ch.smallest = rsp_small_ff;
   assign rsp_ch.is_empty = rsp_empty_ff;
   assign rsp_ch.is_full  = rsp_full_ff;

   `SLIST_ASSERT_NOW(a_no_rw_collision, clock, reset, mem_req.rd_en && mem_req.wr_en,
      mem_req.rd_addr != mem_req.wr_addr)
   `SLIST_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `SLIST_ASSERT_NEXT(a_accept_leaves_idle, clock, reset,
      req_ch.valid && req_ch.ready, state_ff != ST_IDLE)
   `SLIST_ASSERT_NEXT(a_done_posts_rsp, clock, reset,
      (state_ff == ST_DONE) && rsp_free, rsp_valid_ff && (state_ff == ST_IDLE))

endmodule

>>> hw/rtl/sorted_list_engine_core.sv
// Sorted list engine: one request at a time, list held in a single-port-pair RAM.
// Remove and remove-odds read every entry before responding; insert reads from the top down and stops early
// at its slot; a request that fails at once goes straight to the response.
// The RAM read port moves one entry per cycle while a request scans the list.
// A response may wait in its output register while the next request is taken.
// Reset clears the fill count, sequencer and response valid; RAM contents are not cleared.
module sorted_list_engine_core (
   input  logic         clock,
   input  logic         reset,
   slist_req_if.sink    req_ch,
   slist_rsp_if.source  rsp_ch
);
   import slist_pkg::*;

   mem_req_type       mem_req;
   logic [DATA_W-1:0] mem_rd_data;

   slist_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .mem_req     (mem_req),
      .mem_rd_data (mem_rd_data)
   );

   slist_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (DATA_W)
   ) u_ram (
      .clock   (clock),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data)
   );

endmodule

>>> sim/tb.sv
// Testbench for sorted_list_engine_core: random and directed list operations against a shadow list.
`timescale 1ns / 1ps

module tb;
   import slist_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int LIMIT_CYCLES = 1000000;
   localparam int TAIL_CYCLES  = 64;
   localparam int HOLD_CYCLES  = 300;

   typedef struct packed {
      logic                      ok;
      logic [COUNT_FIELD_W-1:0]  count;
      logic signed [DATA_W-1:0]  smallest;
      logic                      is_empty;
      logic                      is_full;
   } list_status_type;

   logic clock = 1'b0;
   logic reset;

   slist_req_if req_if ();
   slist_rsp_if rsp_if ();

   sorted_list_engine_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow copy of the list, updated at each request transfer
   logic signed [DATA_W-1:0] list_img [CAPACITY];
   int                       list_fill = 0;
   list_status_type          pending_status [$];

   int bad_count   = 0;
   int cycle_count = 0;
   bit sender_gaps = 1'b0;
   bit rsp_stalls  = 1'b0;
   bit rsp_hold    = 1'b0;

   function automatic int pick_gap(input int min_len);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return min_len;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return $signed($urandom_range(0, 16)) - 8;
      if (roll < 50) begin
         case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sh8000_0001;
            3: return 32'sh7fff_fffe;
            4: return 32'sh0;
            default: return -32'sd1;
         endcase
      end
      return $urandom();
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_present();
      if (list_fill == 0) return pick_value();
      return list_img[$urandom_range(0, list_fill - 1)];
   endfunction

   function automatic list_status_type apply_list_op(input logic [FUNC_W-1:0] f,
                                                     input logic signed [DATA_W-1:0] v);
      list_status_type st;
      int pos;
      int wr;
      int i;
      st.ok = 1'b0;
      case (f)
         FUNC_INSERT: begin
            if (list_fill < CAPACITY) begin
               pos = 0;
               while (pos < list_fill && list_img[pos] <= v) pos++;
               for (i = list_fill; i > pos; i--) list_img[i] = list_img[i - 1];
               list_img[pos] = v;
               list_fill++;
               st.ok = 1'b1;
            end
         end
         FUNC_REMOVE: begin
            pos = 0;
            while (pos < list_fill && list_img[pos] !== v) pos++;
            if (pos < list_fill) begin
               for (i = pos + 1; i < list_fill; i++) list_img[i - 1] = list_img[i];
               list_fill--;
               st.ok = 1'b1;
            end
         end
         FUNC_ODDS: begin
            if (list_fill != 0) begin
               wr = 0;
               for (i = 0; i < list_fill; i++) begin
                  if (!list_img[i][0]) begin
                     list_img[wr] = list_img[i];
                     wr++;
                  end
               end
               if (wr != list_fill) begin
                  list_fill = wr;
                  st.ok = 1'b1;
               end
            end
         end
         default: st.ok = 1'b0;
      endcase
      st.count    = list_fill[COUNT_FIELD_W-1:0];
      st.smallest = (list_fill > 0) ? list_img[0] : '0;
      st.is_empty = (list_fill == 0);
      st.is_full  = (list_fill == CAPACITY);
      return st;
   endfunction

   task automatic send_op(input logic [FUNC_W-1:0] f, input logic signed [DATA_W-1:0] v);
      int gap;
      gap = sender_gaps ? pick_gap(0) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.func  <= f;
      req_if.value <= v;
      do @(posedge clock); while (!req_if.ready);
      pending_status.push_back(apply_list_op(f, v));
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_status.size() != 0);
   endtask

   task automatic flag_bad(input string what, input logic [DATA_W-1:0] want,
                           input logic [DATA_W-1:0] got);
      bad_count++;
      if (bad_count <= 10)
         $display("mismatch on %s: expected %h, got %h", what, want, got);
   endtask

   // response pacing; the long hold-off is counted here
   initial begin : rsp_pacer
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_hold) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold = 1'b0;
         end else if (rsp_stalls && $urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat (pick_gap(1)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin : rsp_check
      list_status_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_status.size() == 0) begin
            flag_bad("response with none pending", '0, '0);
         end else begin
            want = pending_status.pop_front();
            if (rsp_if.ok !== want.ok)
               flag_bad("ok", DATA_W'(want.ok), DATA_W'(rsp_if.ok));
            if (rsp_if.count !== want.count)
               flag_bad("count", DATA_W'(want.count), DATA_W'(rsp_if.count));
            if (rsp_if.smallest !== want.smallest)
               flag_bad("smallest", want.smallest, rsp_if.smallest);
            if (rsp_if.is_empty !== want.is_empty)
               flag_bad("is_empty", DATA_W'(want.is_empty), DATA_W'(rsp_if.is_empty));
            if (rsp_if.is_full !== want.is_full)
               flag_bad("is_full", DATA_W'(want.is_full), DATA_W'(rsp_if.is_full));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic test_directed();
      sender_gaps = 1'b0;
      rsp_stalls  = 1'b0;
      send_op(FUNC_REMOVE, 32'sd7);           // remove from empty list
      send_op(FUNC_ODDS, 32'sd0);             // remove-odds on empty list
      send_op(FUNC_UNUSED, -32'sd1);
      send_op(FUNC_INSERT, 32'sh7fff_ffff);
      send_op(FUNC_INSERT, 32'sh8000_0000);
      send_op(FUNC_INSERT, 32'sd0);
      send_op(FUNC_INSERT, 32'sd0);           // equal value goes after existing one
      send_op(FUNC_INSERT, -32'sd1);
      send_op(FUNC_INSERT, -32'sd3);
      send_op(FUNC_INSERT, 32'sd5);
      send_op(FUNC_INSERT, 32'sd4);
      send_op(FUNC_REMOVE, 32'sd7);           // absent value
      send_op(FUNC_REMOVE, 32'sh8000_0000);
      send_op(FUNC_REMOVE, 32'sd0);
      send_op(FUNC_UNUSED, 32'sh5a5a_a5a5);
      send_op(FUNC_INSERT, 32'sd9);
      send_op(FUNC_INSERT, 32'sd11);          // adjacent odd entries
      send_op(FUNC_ODDS, 32'sh7fff_ffff);     // negative odds go too
      send_op(FUNC_ODDS, 32'sd0);             // nothing odd left
      send_op(FUNC_REMOVE, 32'sd4);
      send_op(FUNC_REMOVE, 32'sd0);
      send_op(FUNC_ODDS, 32'sd0);
      wait_drained();
   endtask

   task automatic test_fill_drain(input int rounds);
      int r;
      for (r = 0; r < rounds; r++) begin
         sender_gaps = ($urandom_range(0, 1) == 1);
         rsp_stalls  = ($urandom_range(0, 1) == 1);
         while (list_fill < CAPACITY) send_op(FUNC_INSERT, pick_value());
         repeat (3) send_op(FUNC_INSERT, pick_value());   // list full
         send_op(FUNC_UNUSED, pick_value());
         while (list_fill > 0) begin
            if ($urandom_range(0, 99) < 85) send_op(FUNC_REMOVE, pick_present());
            else send_op(FUNC_REMOVE, pick_value());
         end
         send_op(FUNC_ODDS, pick_value());
      end
      wait_drained();
   endtask

   task automatic test_backpressure();
      sender_gaps = 1'b0;
      rsp_stalls  = 1'b0;
      rsp_hold    = 1'b1;
      repeat (12) send_op(FUNC_INSERT, pick_value());
      // sender pauses here until the list engine has answered everything
      wait_drained();
      send_op(FUNC_REMOVE, pick_present());
      wait_drained();
   endtask

   task automatic test_random_mix(input int n_items);
      int done_items;
      int block_len;
      int ins_pct;
      int rmp_pct;
      int rmr_pct;
      int odd_pct;
      int roll;
      int k;
      done_items = 0;
      while (done_items < n_items) begin
         block_len   = $urandom_range(20, 80);
         sender_gaps = ($urandom_range(0, 3) != 0);
         rsp_stalls  = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 2))
            0:       begin ins_pct = 80; rmp_pct = 10; rmr_pct = 4;  odd_pct = 3; end
            1:       begin ins_pct = 20; rmp_pct = 60; rmr_pct = 10; odd_pct = 7; end
            default: begin ins_pct = 50; rmp_pct = 30; rmr_pct = 8;  odd_pct = 9; end
         endcase
         for (k = 0; k < block_len; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < ins_pct)
               send_op(FUNC_INSERT, pick_value());
            else if (roll < ins_pct + rmp_pct)
               send_op(FUNC_REMOVE, pick_present());
            else if (roll < ins_pct + rmp_pct + rmr_pct)
               send_op(FUNC_REMOVE, pick_value());
            else if (roll < ins_pct + rmp_pct + rmr_pct + odd_pct)
               send_op(FUNC_ODDS, pick_value());
            else
               send_op(FUNC_UNUSED, pick_value());
         end
         if ($urandom_range(0, 4) == 0) wait_drained();
         done_items += block_len;
      end
      wait_drained();
   endtask

   initial begin
      req_if.valid <= 1'b0;
      req_if.func  <= FUNC_INSERT;
      req_if.value <= '0;
      reset        <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_fill_drain(2);
      test_backpressure();
      test_random_mix(1450);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (bad_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
